// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, switched off while reset is asserted
`define GTM_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("gtm assertion failed");

// concurrent check that also runs through reset
`define GTM_ASSERT_NR(name, clk, prop) \
    name: assert property (@(posedge clk) (prop)) \
        else $error("gtm assertion failed");

`endif

// ===== src/gtm_pkg.sv =====
// shared types, constants and helper functions of the goertzel tone magnitude core
// no dependencies
package gtm_pkg;

    localparam int GTM_QDEPTH   = 4;
    localparam int GTM_CHANNELS = 8;

    localparam int SAMPLE_W = 16;
    localparam int CHAN_W   = 3;
    localparam int CFG_W    = 32;
    localparam int IDX_W    = 3;
    localparam int Q_W      = 56;
    localparam int COEF_W   = 33;
    localparam int X_W      = 48;
    localparam int MAG_W    = 32;

    localparam logic signed [Q_W-1:0] Q_MAX = {1'b0, {(Q_W-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = {1'b1, {(Q_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        REG_BLOCK_LENGTH     = 3'd0,
        REG_SELECTED_CHANNEL = 3'd1,
        REG_FEEDBACK_COEFF   = 3'd2,
        REG_COSINE_TERM      = 3'd3,
        REG_SINE_TERM        = 3'd4,
        REG_INPUT_SCALE      = 3'd5,
        REG_OUTPUT_SCALE     = 3'd6
    } t_reg_idx;

    typedef struct packed {
        logic        [15:0] block_length;
        logic [CHAN_W-1:0]  selected_channel;
        logic signed [31:0] feedback_coeff;
        logic signed [31:0] cosine_term;
        logic signed [31:0] sine_term;
        logic        [31:0] input_scale;
        logic        [31:0] output_scale;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        block_length:     16'd100,
        selected_channel: 3'd0,
        feedback_coeff:   32'sd0,
        cosine_term:      32'sd1073741824,
        sine_term:        32'sd0,
        input_scale:      32'd65536,
        output_scale:     32'd21474836
    };

    // request into the shared q30 multiplier
    typedef struct packed {
        logic                     start;
        logic signed [Q_W-1:0]    a;
        logic signed [COEF_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic                  done;
        logic signed [Q_W-1:0] res;
    } t_mul_rsp;

    // request into the square root unit
    typedef struct packed {
        logic        sat;
        logic [63:0] radicand;
    } t_sqrt_req;

    function automatic logic signed [Q_W-1:0] sat56(input logic [Q_W+1:0] v);
        logic signed [Q_W-1:0] r;
        if (v[Q_W+1:Q_W-1] == 3'b000 || v[Q_W+1:Q_W-1] == 3'b111) begin
            r = v[Q_W-1:0];
        end else if (v[Q_W+1]) begin
            r = Q_MIN;
        end else begin
            r = Q_MAX;
        end
        return r;
    endfunction

    function automatic logic [Q_W-1:0] abs56(input logic [Q_W-1:0] v);
        logic [Q_W-1:0] r;
        r = v[Q_W-1] ? (~v + {{(Q_W-1){1'b0}}, 1'b1}) : v;
        return r;
    endfunction

endpackage

// ===== src/goertzel_tone_magnitude_core.sv =====
// single-bin goertzel tone magnitude detector, top level
// depends on gtm_pkg, gtm_front, gtm_back, gtm_mul and gtm_sqrt
//
// Tagged ADC samples go in through a queue-style push/full port; samples whose channel
// tag matches selected_channel are kept, scaled by input_scale and run through the
// recurrence q0 = 2cos*q1 - q2 + x (56-bit Q.16 state, saturating). After block_length
// kept samples one magnitude sqrt(re^2 + im^2) in unsigned Q16.16 comes out through
// the empty/pop port, and the filter state is cleared. A sample on another channel
// is dropped at the front. A kept sample occupies the back end for one pass
// through the shared 56x32 multiplier (steps LO, HI, SUM and RND); a block end then
// adds four more multiplies and the squaring, and the square root runs while the
// back end already works on the next block. The front queue holds QDEPTH kept
// samples, so short bursts are taken at one per cycle while the queue is not full.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must
// write them only while the block is idle, which the block itself does not enforce;
// writes never clear the filter state, and a block length of zero acts as one.
module goertzel_tone_magnitude_core import gtm_pkg::*; #(
    parameter int QDEPTH = GTM_QDEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // sample input channel
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [CHAN_W-1:0]   i_channel,
    // magnitude result channel
    output logic                empty,
    input  logic                pop,
    output logic [MAG_W-1:0]    o_magnitude,
    // register write port
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [CFG_W-1:0]    i_cfg_wdata
);

    t_cfg                r_cfg;

    // front to back queue signals
    logic                q_empty;
    logic                q_pop;
    logic [SAMPLE_W-1:0] q_sample;

    // back to square root hand-off
    logic                sq_valid;
    logic                sq_ready;
    t_sqrt_req           sq_req;

    // configuration registers, indexed in list order; unknown index is dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_BLOCK_LENGTH:     r_cfg.block_length     <= i_cfg_wdata[15:0];
                REG_SELECTED_CHANNEL: r_cfg.selected_channel <= i_cfg_wdata[CHAN_W-1:0];
                REG_FEEDBACK_COEFF:   r_cfg.feedback_coeff   <= i_cfg_wdata;
                REG_COSINE_TERM:      r_cfg.cosine_term      <= i_cfg_wdata;
                REG_SINE_TERM:        r_cfg.sine_term        <= i_cfg_wdata;
                REG_INPUT_SCALE:      r_cfg.input_scale      <= i_cfg_wdata;
                REG_OUTPUT_SCALE:     r_cfg.output_scale     <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // front: channel filter plus queue of kept samples
    gtm_front #(
        .DEPTH (QDEPTH)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .o_full    (full),
        .i_sample  (i_sample),
        .i_channel (i_channel),
        .i_sel     (r_cfg.selected_channel),
        .o_empty   (q_empty),
        .i_pop     (q_pop),
        .o_sample  (q_sample)
    );

    // back: recurrence, block-end real/imag terms and their squares
    gtm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_q_empty  (q_empty),
        .i_q_sample (q_sample),
        .o_q_pop    (q_pop),
        .o_sq_valid (sq_valid),
        .o_sq_req   (sq_req),
        .i_sq_ready (sq_ready)
    );

    // square root with its own result register, drives the result port
    gtm_sqrt u_sqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (sq_valid),
        .i_req       (sq_req),
        .o_ready     (sq_ready),
        .o_empty     (empty),
        .i_pop       (pop),
        .o_magnitude (o_magnitude)
    );

endmodule

// ===== src/gtm_front.sv =====
// front end: channel filter and short queue of kept samples
// depends on gtm_pkg
module gtm_front import gtm_pkg::*; #(
    parameter int DEPTH = GTM_QDEPTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_push,
    output logic                o_full,
    input  logic [SAMPLE_W-1:0] i_sample,
    input  logic [CHAN_W-1:0]   i_channel,
    input  logic [CHAN_W-1:0]   i_sel,
    output logic                o_empty,
    input  logic                i_pop,
    output logic [SAMPLE_W-1:0] o_sample
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [SAMPLE_W-1:0] r_mem [DEPTH];
    logic [PW-1:0]       r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]       r_cnt;
    logic                keep, wr_en, rd_en;

    assign keep    = (i_channel == i_sel) && (int'(i_channel) < GTM_CHANNELS);
    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign wr_en   = i_push && !o_full && keep;
    assign rd_en   = i_pop && !o_empty;
    assign o_sample = r_mem[r_rd];

    assign n_wr = (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (wr_en) begin
                r_wr <= n_wr;
            end
            if (rd_en) begin
                r_rd <= n_rd;
            end
            if (wr_en && !rd_en) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (rd_en && !wr_en) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr] <= i_sample;
        end
    end

endmodule

// ===== src/gtm_mul.sv =====
// shared q2.30 multiplier: round half away from zero, saturate to 56 bits
// depends on gtm_pkg; one 32x28 multiplier used for the low and high halves
module gtm_mul import gtm_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    typedef enum logic [2:0] {M_IDLE, M_LO, M_HI, M_SUM, M_RND} t_state;

    localparam logic [57:0] NEG_LIM = 58'd1 << 55;
    localparam logic [87:0] HALF    = 88'd1 << 29;

    t_state                r_state;
    logic [Q_W-1:0]        r_mq;
    logic [31:0]           r_mc;
    logic                  r_neg;
    logic [59:0]           r_acc, r_p;
    logic [87:0]           r_sum;
    logic signed [Q_W-1:0] r_res;
    logic                  r_done;

    logic [COEF_W-1:0]     b_u, b_neg;
    logic [31:0]           b_mag;
    logic [27:0]           half_q;
    logic [59:0]           prod;
    logic [57:0]           m;
    logic [57:0]           m_neg;
    logic signed [Q_W-1:0] rnd;

    assign b_u    = i_req.b;
    assign b_neg  = ~b_u + {{(COEF_W-1){1'b0}}, 1'b1};
    assign b_mag  = b_u[COEF_W-1] ? b_neg[31:0] : b_u[31:0];
    assign half_q = (r_state == M_LO) ? r_mq[27:0] : r_mq[55:28];
    assign prod   = {28'd0, r_mc} * {32'd0, half_q};
    assign m      = r_sum[87:30];
    assign m_neg  = ~m + 58'd1;

    always_comb begin
        if (r_neg) begin
            rnd = (m > NEG_LIM) ? Q_MIN : m_neg[Q_W-1:0];
        end else begin
            rnd = (|m[57:55]) ? Q_MAX : m[Q_W-1:0];
        end
    end

    assign o_rsp = '{done: r_done, res: r_res};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= (r_state == M_RND);
            case (r_state)
                M_IDLE: begin
                    if (i_req.start) begin
                        r_mq    <= abs56(i_req.a);
                        r_mc    <= b_mag;
                        r_neg   <= i_req.a[Q_W-1] ^ b_u[COEF_W-1];
                        r_state <= M_LO;
                    end
                end
                M_LO: begin
                    r_acc   <= prod;
                    r_state <= M_HI;
                end
                M_HI: begin
                    r_p     <= prod;
                    r_state <= M_SUM;
                end
                M_SUM: begin
                    r_sum   <= {r_p, 28'd0} + {28'd0, r_acc} + HALF;
                    r_state <= M_RND;
                end
                M_RND: begin
                    r_res   <= rnd;
                    r_state <= M_IDLE;
                end
                default: begin
                    r_state <= M_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/gtm_back.sv =====
// back end: goertzel recurrence, block-end combine and squaring
// depends on gtm_pkg and gtm_mul
module gtm_back import gtm_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_cfg                i_cfg,
    input  logic                i_q_empty,
    input  logic [SAMPLE_W-1:0] i_q_sample,
    output logic                o_q_pop,
    output logic                o_sq_valid,
    output t_sqrt_req           o_sq_req,
    input  logic                i_sq_ready
);

    typedef enum logic [3:0] {
        S_IDLE, S_REC, S_COS, S_SIN, S_RE, S_IM, S_SQA, S_SQB, S_SUM, S_ROOT
    } t_state;

    t_state                r_state;
    logic signed [Q_W-1:0] r_q1, r_q2, r_re, r_im;
    logic [X_W-1:0]        r_x;
    logic [15:0]           r_cnt;
    logic [63:0]           r_sqa, r_sqb;
    logic [64:0]           r_rad;
    logic                  r_big;

    t_mul_req              mul_req;
    t_mul_rsp              mul_rsp;
    logic [15:0]           cnt_inc;
    logic                  emit;
    logic [Q_W+1:0]        rec_sum, re_diff;
    logic [Q_W-1:0]        abs_re, abs_im;
    logic [31:0]           sq_src;
    logic [63:0]           sq;
    logic [X_W-1:0]        x_prod;
    logic [COEF_W-1:0]     fb_ext, cos_ext, sin_ext, osc_ext;

    gtm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    assign fb_ext  = {i_cfg.feedback_coeff[31], i_cfg.feedback_coeff};
    assign cos_ext = {i_cfg.cosine_term[31], i_cfg.cosine_term};
    assign sin_ext = {i_cfg.sine_term[31], i_cfg.sine_term};
    assign osc_ext = {1'b0, i_cfg.output_scale};

    assign cnt_inc = r_cnt + 16'd1;
    assign emit    = !(cnt_inc < i_cfg.block_length);
    assign x_prod  = {32'd0, i_q_sample} * {16'd0, i_cfg.input_scale};

    // q0 = p - q2 + x, and q1 - q2*cos, both in 58 bits before saturation
    assign rec_sum = {{2{mul_rsp.res[Q_W-1]}}, mul_rsp.res} - {{2{r_q2[Q_W-1]}}, r_q2}
                   + {10'd0, r_x};
    assign re_diff = {{2{r_q1[Q_W-1]}}, r_q1} - {{2{mul_rsp.res[Q_W-1]}}, mul_rsp.res};

    assign abs_re = abs56(r_re);
    assign abs_im = abs56(r_im);
    assign sq_src = (r_state == S_SQA) ? abs_re[31:0] : abs_im[31:0];
    assign sq     = {32'd0, sq_src} * {32'd0, sq_src};

    assign o_q_pop    = (r_state == S_IDLE) && !i_q_empty;
    assign o_sq_valid = (r_state == S_ROOT);
    assign o_sq_req   = '{sat: r_big | r_rad[64], radicand: r_rad[63:0]};

    always_comb begin
        mul_req = '{start: 1'b0, a: r_q1, b: fb_ext};
        case (r_state)
            S_IDLE: mul_req = '{start: !i_q_empty, a: r_q1, b: fb_ext};
            S_REC:  mul_req = '{start: mul_rsp.done && emit, a: r_q1, b: cos_ext};
            S_COS:  mul_req = '{start: mul_rsp.done, a: r_q2, b: sin_ext};
            S_SIN:  mul_req = '{start: mul_rsp.done, a: r_re, b: osc_ext};
            S_RE:   mul_req = '{start: mul_rsp.done, a: r_im, b: osc_ext};
            default: mul_req = '{start: 1'b0, a: r_q1, b: fb_ext};
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_q1    <= '0;
            r_q2    <= '0;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_x     <= x_prod;
                        r_state <= S_REC;
                    end
                end
                S_REC: begin
                    if (mul_rsp.done) begin
                        r_q1 <= sat56(rec_sum);
                        r_q2 <= r_q1;
                        if (emit) begin
                            r_cnt   <= '0;
                            r_state <= S_COS;
                        end else begin
                            r_cnt   <= cnt_inc;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_COS: begin
                    if (mul_rsp.done) begin
                        r_re    <= sat56(re_diff);
                        r_state <= S_SIN;
                    end
                end
                S_SIN: begin
                    if (mul_rsp.done) begin
                        r_im    <= mul_rsp.res;
                        r_state <= S_RE;
                    end
                end
                S_RE: begin
                    if (mul_rsp.done) begin
                        r_re    <= mul_rsp.res;
                        r_state <= S_IM;
                    end
                end
                S_IM: begin
                    if (mul_rsp.done) begin
                        r_im    <= mul_rsp.res;
                        r_state <= S_SQA;
                    end
                end
                S_SQA: begin
                    r_sqa   <= sq;
                    r_big   <= |abs_re[Q_W-1:32];
                    r_state <= S_SQB;
                end
                S_SQB: begin
                    r_sqb   <= sq;
                    r_big   <= r_big | (|abs_im[Q_W-1:32]);
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_rad   <= {1'b0, r_sqa} + {1'b0, r_sqb};
                    r_state <= S_ROOT;
                end
                S_ROOT: begin
                    if (i_sq_ready) begin
                        r_q1    <= '0;
                        r_q2    <= '0;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/gtm_sqrt.sv =====
// bit-pair integer square root with a one-entry result register
// depends on gtm_pkg
module gtm_sqrt import gtm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  t_sqrt_req        i_req,
    output logic             o_ready,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [MAG_W-1:0] o_magnitude
);

    typedef enum logic [1:0] {R_IDLE, R_RUN, R_HOLD} t_state;

    t_state           r_state;
    logic [63:0]      r_n, r_res, r_bit;
    logic             r_out_valid;
    logic [MAG_W-1:0] r_mag;
    logic [63:0]      trial;
    logic             ge;
    logic             load;

    assign trial       = r_res + r_bit;
    assign ge          = (r_n >= trial);
    assign load        = (r_state == R_HOLD) && (!r_out_valid || i_pop);
    assign o_ready     = (r_state == R_IDLE);
    assign o_empty     = !r_out_valid;
    assign o_magnitude = r_mag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= R_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (i_pop && r_out_valid) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                R_IDLE: begin
                    if (i_valid) begin
                        if (i_req.sat) begin
                            r_res   <= {32'd0, {MAG_W{1'b1}}};
                            r_state <= R_HOLD;
                        end else begin
                            r_n     <= i_req.radicand;
                            r_res   <= '0;
                            r_bit   <= 64'd1 << 62;
                            r_state <= R_RUN;
                        end
                    end
                end
                R_RUN: begin
                    if (ge) begin
                        r_n   <= r_n - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_state <= R_HOLD;
                    end
                end
                R_HOLD: begin
                    if (load) begin
                        r_mag   <= r_res[MAG_W-1:0];
                        r_state <= R_IDLE;
                    end
                end
                default: begin
                    r_state <= R_IDLE;
                end
            endcase
        end
    end

endmodule

// ===== src/gtm_checker.sv =====
// port-level checks for the goertzel tone magnitude core, bound to the top level
// depends on gtm_pkg and assert_macros.svh
`include "assert_macros.svh"

module gtm_checker import gtm_pkg::*; (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             push,
    input logic             full,
    input logic             empty,
    input logic             pop,
    input logic [MAG_W-1:0] o_magnitude
);

    // reset leaves the result side empty and the input queue not full
    `GTM_ASSERT_NR(a_reset_clears, i_clk, !i_rst_n |=> empty && !full)

    // input queue only fills after a push
    `GTM_ASSERT(a_full_needs_push, i_clk, i_rst_n, $rose(full) |-> $past(push))

    // a waiting result is neither dropped nor changed until popped
    `GTM_ASSERT(a_result_kept, i_clk, i_rst_n, !empty && !pop |=> !empty)
    `GTM_ASSERT(a_result_stable, i_clk, i_rst_n, !empty && !pop |=> $stable(o_magnitude))

endmodule

bind goertzel_tone_magnitude_core gtm_checker u_gtm_checker (.*);
